>>> rtl/lbs_pkg.sv
package lbs_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // per-cycle command to the cell column
    typedef struct packed {
        logic push;   // shift toward bottom, new word into top
        logic pop;    // shift toward top
        logic rot;    // rotate the live entries by one toward top
    } lbs_cell_ctrl_t;

endpackage

>>> rtl/bounded_lifo_stack_with_search.sv
// Push, pop, peek, clear and unknown commands: result strobe in the cycle after start is
// taken, and a new command is taken every cycle (busy stays low).
// Search: busy while the live entries rotate past the top cell, which is compared to the
// key; result in the cycle after the last step. An empty search returns not found without a walk.
// Reset: count cleared, capacity back to 64, no result pending; entries are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bounded_lifo_stack_with_search
    import lbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // command transfer
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   cmd,
    input  logic signed [WORD_WIDTH-1:0] value,
    // configuration transfer
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CAP_W-1:0]             cfg_data,
    // result strobe
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [WORD_WIDTH-1:0] data,
    output logic [IDX_W-1:0]             found_index,
    output logic [CNT_W-1:0]             count,
    output logic                         empty_res,
    output logic                         full_res
);

    // common width for count against capacity compares
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t                 state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [WORD_WIDTH-1:0]  key_reg, key_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       found_reg, found_next;

    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic [WORD_WIDTH-1:0]  data_reg, data_next;
    logic [IDX_W-1:0]       fidx_reg, fidx_next;
    logic                   empty_reg, empty_next;
    logic                   full_reg, full_next;

    logic                   accept;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   top_match;
    logic [IDX_W-1:0]       step_pos;
    lbs_cell_ctrl_t         ctrl;

    logic [WORD_WIDTH-1:0]  cell_word [DEPTH];

    // ------------------------------------------------------------------
    // Cell column: cell 0 is the top of stack, cell i holds the entry at
    // bottom-based position count-1-i.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] above_w;
        logic [WORD_WIDTH-1:0] below_w;

        if (i == 0)
        begin : g_top
            assign above_w = value;
        end
        else
        begin : g_mid
            assign above_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below_w = cell_word[0];
        end
        else
        begin : g_body
            assign below_w = cell_word[i+1];
        end

        lbs_cell #(
            .INDEX      (i),
            .WORD_WIDTH (WORD_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .above_word (above_w),
            .below_word (below_w),
            .wrap_word  (cell_word[0]),
            .word       (cell_word[i])
        );
    end

    assign accept = start && !busy_reg;

    // capacity above DEPTH saturates to DEPTH
    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign cnt_ext = CMP_W'(count_reg);

    // during search, step k looks at the entry at position count-1-k
    assign top_match = (cell_word[0] == key_reg);
    assign step_pos  = IDX_W'(count_reg - step_reg - CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        cap_next    = cap_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        key_next    = key_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        fidx_next   = fidx_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;
        ctrl        = '0;

        // the user must write it only while idle, so no interaction with commands; the block does not enforce this
        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    fidx_next   = '0;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            if (cnt_ext >= eff_cap)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.push  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.pop   = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                data_next  = cell_word[0];
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                data_next = cell_word[0];
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                // walk the column; result comes at the end
                                done_next  = 1'b0;
                                state_next = S_SEARCH;
                                busy_next  = 1'b1;
                                step_next  = '0;
                                key_next   = value;
                                hit_next   = 1'b0;
                                found_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                ctrl.rot  = 1'b1;
                step_next = step_reg + CNT_W'(1);
                if (top_match && !hit_reg)
                begin
                    hit_next   = 1'b1;
                    found_next = step_pos;
                end
                // after count steps the column is back in its original order
                if (step_reg == count_reg - CNT_W'(1))
                begin
                    state_next  = S_IDLE;
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    data_next   = '0;
                    if (hit_reg)
                    begin
                        status_next = ST_OK;
                        fidx_next   = found_reg;
                    end
                    else if (top_match)
                    begin
                        status_next = ST_OK;
                        fidx_next   = step_pos;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        fidx_next   = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase

        empty_next = (count_next == '0);
        full_next  = (CMP_W'(count_next) >= eff_cap);
        if (!done_next)
        begin
            empty_next = empty_reg;
            full_next  = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            cap_reg    <= CAP_RESET;
            count_reg  <= '0;
            step_reg   <= '0;
            hit_reg    <= 1'b0;
            found_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            data_reg   <= '0;
            fidx_reg   <= '0;
            empty_reg  <= 1'b1;
            full_reg   <= 1'b0;
            key_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            cap_reg    <= cap_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            hit_reg    <= hit_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            fidx_reg   <= fidx_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
            key_reg    <= key_next;
        end
    end

    assign busy        = busy_reg;
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign status      = status_reg;
    assign data        = data_reg;
    assign found_index = fidx_reg;
    assign count       = count_reg;
    assign empty_res   = empty_reg;
    assign full_res    = full_reg;

endmodule

>>> rtl/lbs_cell.sv
module lbs_cell
    import lbs_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CNT_W = 7
)
(
    input  logic                  clk,
    input  lbs_cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [WORD_WIDTH-1:0] above_word,
    input  logic [WORD_WIDTH-1:0] below_word,
    input  logic [WORD_WIDTH-1:0] wrap_word,
    output logic [WORD_WIDTH-1:0] word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  is_bottom;

    // lowest live entry takes the old top during rotation
    assign is_bottom = (count == CNT_W'(INDEX + 1));

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.push)
        begin
            word_next = above_word;
        end
        else if (ctrl.pop)
        begin
            word_next = below_word;
        end
        else if (ctrl.rot)
        begin
            word_next = is_bottom ? wrap_word : below_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
